// File: sv/tvss_pkg.sv
// tvss_pkg: shared types, constants and the quarter-wave sine entry function for the three-voice sine synthesizer
// no dependencies
package tvss_pkg;

	localparam int STEP_W  = 28;
	localparam int PITCH_W = 24;
	localparam int GAIN_W  = 24;
	localparam int RATE_W  = 28;
	localparam int SINE_W  = 16;

	localparam logic [1:0] REG_SMOOTH_RATE = 2'd0;
	localparam logic [1:0] REG_PULSE_THR   = 2'd1;
	localparam logic [1:0] REG_PULSE_FLOOR = 2'd2;
	localparam logic [1:0] REG_PULSE_MIN   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_PULSE_DIV,
		ST_PULSE_LOOK,
		ST_VOICE,
		ST_LOOK,
		ST_MIX_GAIN,
		ST_MIX_GATE,
		ST_ROUND,
		ST_OUT
	} state_t;

	// serial multiplier and divider control
	typedef struct packed {
		logic start;
		logic busy;
	} mul_ctl_t;

	// quarter-wave sine entry, Taylor series in Q30, rounded to Q1.14
	function automatic logic [14:0] quarter_entry(input int unsigned q, input int tbits);
		logic [63:0] x, x2, t, w;
		logic signed [63:0] sum, r;
		begin
			x = (64'(q) * 64'd6746518852) >> tbits;
			x2 = (x * x) >> 30;
			t = x;
			sum = $signed(x);
			for (int k = 1; k <= 5; k++) begin
				w = (t * x2) >> 30;
				t = w / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) sum = sum - $signed(t);
				else sum = sum + $signed(t);
			end
			if (sum < 0) sum = 0;
			r = (sum + 64'sd32768) >>> 16;
			if (r > 64'sd16384) r = 64'sd16384;
			return r[14:0];
		end
	endfunction

endpackage

// File: sv/three_voice_sine_synth_top.sv
// three_voice_sine_synth_top: smoothed three-voice sine mixer with pulse gate
// depends on tvss_pkg, tvss_mul, tvss_div
// processing: one sample in flight; each product is formed on the shared 40-bit serial
//   multiplier (three smoothing, three voice steps, gain, and the gate only while it is
//   closed), active pulse gating adds the pulse step divide and a lookup state, and the
//   output waits for the rounding divide
// handshake: s_tready rises the cycle after the output transfer; a muted sample has its
//   output valid in the cycle after its transfer
// reset: registers to defaults, phases and pulse rate zero, pitch 1.0, gain 0.2
module three_voice_sine_synth_top import tvss_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int PHASE_BITS      = 32,
	parameter int SAMPLE_RATE_HZ  = 44100
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// voice1_step[27:0], voice2_step[55:28], voice3_step[83:56],
	// target_pitch[98:84], target_gain[114:99], target_pulse_rate[130:115], zero pad
	input  logic [135:0]  s_tdata,
	input  logic          s_tlast,   // block_last
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,   // sample[15:0]
	output logic          m_tlast,   // period_last
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	localparam int TB    = SINE_TABLE_BITS;
	localparam int PB    = PHASE_BITS;
	localparam int QN    = 1 << (TB - 2);
	localparam int VSH   = 54 - PB;
	localparam int DEN_W = 48;
	localparam int NUM_W = RATE_W + PB;
	localparam logic [DEN_W-1:0] PULSE_DEN = DEN_W'(SAMPLE_RATE_HZ) << 24;
	localparam logic [41:0] RDIV_DEN = 42'd3 << 39;

	// quarter-wave table, constant logic
	function automatic logic [14:0] qtab(input logic [TB-2:0] i);
		logic [14:0] v;
		begin
			v = '0;
			for (int k = 0; k < QN; k++)
				if (i == (TB-1)'(k)) v = quarter_entry(k, TB);
			return v;
		end
	endfunction

	function automatic logic [14:0] qend();
		return quarter_entry(QN, TB);
	endfunction

	function automatic logic signed [15:0] sine_of(input logic [PB-1:0] ph);
		logic [TB-1:0]   idx;
		logic [TB-3:0]   rem;
		logic [TB-1:0]   mir;
		logic [14:0]     v;
		begin
			idx = ph[PB-1 -: TB];
			rem = idx[TB-3:0];
			mir = TB'(QN) - TB'(rem);
			if (idx[TB-2])
				v = (rem == '0) ? qend() : qtab(mir[TB-2:0]);
			else
				v = qtab({1'b0, rem});
			return idx[TB-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
		end
	endfunction

	// configuration registers
	logic [15:0] smooth_rate_q, pulse_floor_q, pulse_min_q;
	logic [14:0] pulse_thr_q;

	// state
	logic [PB-1:0]     ph1_q, ph2_q, ph3_q, php_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [RATE_W-1:0]  prate_q;

	// item
	logic [STEP_W-1:0] st1_q, st2_q, st3_q;
	logic [14:0] tp_q;
	logic [15:0] tg_q, tr_q;
	logic        last_q;

	state_t st_q, st_d;
	logic [2:0]  sub_q;
	logic signed [17:0] mix_q;
	logic [15:0] gate_q;
	logic        gate_open_q;
	logic        neg_q;
	logic [79:0] mag_q;
	logic        out_v_q;
	logic [15:0] out_d_q;
	logic        out_l_q;

	// shared serial multiplier, 40 x 40
	logic        mul_go;
	logic [39:0] mul_a, mul_b;
	mul_ctl_t    mul_ctl;
	logic [79:0] mul_p;
	logic        mul_pend_q;

	tvss_mul #(.A_W(40), .B_W(40)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.ctl(mul_ctl), .prod(mul_p)
	);

	logic           div_go;
	mul_ctl_t       div_ctl;
	logic [NUM_W-1:0] div_q;

	tvss_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(NUM_W'(prate_q) << PB), .den(PULSE_DEN), .ctl(div_ctl), .quo(div_q)
	);

	// multiplier or divider busy or just started
	logic mul_wait, div_wait;
	assign mul_wait = mul_ctl.busy || mul_ctl.start;
	assign div_wait = div_ctl.busy || div_ctl.start;

	assign s_tready  = (st_q == ST_IDLE) && !out_v_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_d_q;
	assign m_tlast   = out_l_q;

	// smoothing difference, signed, sized to hold all three cases
	logic signed [29:0] sdiff;
	logic signed [46:0] sprod;
	logic signed [46:0] sq;
	always_comb begin
		case (sub_q)
			3'd0: sdiff = $signed({7'd0, tp_q, 8'd0}) - $signed({6'd0, pitch_q});
			3'd1: sdiff = $signed({6'd0, tg_q, 8'd0}) - $signed({6'd0, gain_q});
			default: sdiff = $signed({2'd0, tr_q, 12'd0}) - $signed({2'd0, prate_q});
		endcase
		// two's complement product from the unsigned multiply of |diff|
		sprod = sdiff[29] ? -$signed({1'b0, mul_p[45:0]}) : $signed({1'b0, mul_p[45:0]});
		sq    = sprod >>> 16;
	end

	logic [29:0] sabs;
	assign sabs = sdiff[29] ? 30'(-sdiff) : 30'(sdiff);

	logic [STEP_W-1:0] cur_step;
	always_comb begin
		case (sub_q)
			3'd0:    cur_step = st1_q;
			3'd1:    cur_step = st2_q;
			default: cur_step = st3_q;
		endcase
	end

	logic signed [15:0] sin1, sin2, sin3, sinp;
	assign sin1 = sine_of(ph1_q);
	assign sin2 = sine_of(ph2_q);
	assign sin3 = sine_of(ph3_q);
	assign sinp = sine_of(php_q);

	logic [79:0] round_sum;
	assign round_sum = mag_q + (80'd3 << 38);

	// next state and multiplier operands
	always_comb begin
		st_d   = st_q;
		mul_go = 1'b0;
		div_go = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (st_q)
			ST_IDLE: if (s_tvalid && s_tready) st_d = ST_SMOOTH;
			ST_SMOOTH: begin
				mul_a = 40'(sabs);
				mul_b = 40'(smooth_rate_q);
				if (!mul_pend_q) mul_go = 1'b1;
				else if (!mul_wait && sub_q == 3'd2) st_d = ST_PULSE_DIV;
			end
			ST_PULSE_DIV: begin
				if (prate_q <= RATE_W'({pulse_min_q, 12'd0})) st_d = ST_VOICE;
				else if (!mul_pend_q) div_go = 1'b1;
				else if (!div_wait) st_d = ST_PULSE_LOOK;
			end
			ST_PULSE_LOOK: st_d = ST_VOICE;
			ST_VOICE: begin
				mul_a = 40'(cur_step);
				mul_b = 40'(pitch_q);
				if (!mul_pend_q) mul_go = 1'b1;
				else if (!mul_wait && sub_q == 3'd2) st_d = ST_LOOK;
			end
			ST_LOOK: st_d = ST_MIX_GAIN;
			ST_MIX_GAIN: begin
				mul_a = 40'(neg_q ? -mix_q : mix_q);
				mul_b = 40'(gain_q);
				if (!mul_pend_q) mul_go = 1'b1;
				else if (!mul_wait) st_d = ST_MIX_GATE;
			end
			ST_MIX_GATE: begin
				mul_a = mag_q[39:0];
				mul_b = 40'(gate_q);
				// open gate skips the multiplier
				if (gate_open_q) st_d = ST_ROUND;
				else if (!mul_pend_q) mul_go = 1'b1;
				else if (!mul_wait) st_d = ST_ROUND;
			end
			ST_ROUND: if (!mul_pend_q) st_d = ST_OUT;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// division of the rounded product by 3*2^39 uses a serial divider too
	logic        rdiv_go;
	mul_ctl_t    rdiv_ctl;
	logic [79:0] rdiv_q;
	assign rdiv_go = (st_q == ST_ROUND) && (sub_q == 3'd0);
	tvss_div #(.N_W(80), .D_W(42)) u_rdiv (
		.clk(clk), .arst_n(arst_n), .start(rdiv_go),
		.num(round_sum), .den(RDIV_DEN), .ctl(rdiv_ctl), .quo(rdiv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			sub_q         <= '0;
			mul_pend_q    <= 1'b0;
			out_v_q       <= 1'b0;
			out_d_q       <= '0;
			out_l_q       <= 1'b0;
			gate_q        <= '0;
			gate_open_q   <= 1'b1;
			mix_q         <= '0;
			neg_q         <= 1'b0;
			mag_q         <= '0;
			smooth_rate_q <= 16'd328;
			pulse_thr_q   <= 15'h7333;
			pulse_floor_q <= 16'd9830;
			pulse_min_q   <= 16'd4096;
			ph1_q <= '0; ph2_q <= '0; ph3_q <= '0; php_q <= '0;
			pitch_q <= 24'd4194304;
			gain_q  <= 24'd3355443;
			prate_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SMOOTH_RATE: smooth_rate_q <= cfg_data;
					REG_PULSE_THR:   pulse_thr_q   <= cfg_data[14:0];
					REG_PULSE_FLOOR: pulse_floor_q <= cfg_data;
					REG_PULSE_MIN:   pulse_min_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (mul_go || div_go) mul_pend_q <= 1'b1;
			case (st_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					sub_q <= '0;
					if (s_tdata[27:0] == '0) begin
						// muted sample, state frozen
						out_v_q <= 1'b1;
						out_d_q <= '0;
						out_l_q <= s_tlast;
						st_q    <= ST_IDLE;
					end else st_q <= st_d;
				end
				ST_SMOOTH: begin
					if (mul_pend_q && !mul_wait) begin
						mul_pend_q <= 1'b0;
						sub_q <= (sub_q == 3'd2) ? 3'd0 : sub_q + 1'b1;
						case (sub_q)
							3'd0: pitch_q <= PITCH_W'($signed({23'd0, pitch_q}) + sq);
							3'd1: gain_q  <= GAIN_W'($signed({23'd0, gain_q}) + sq);
							default: prate_q <= RATE_W'($signed({19'd0, prate_q}) + sq);
						endcase
					end
					st_q <= st_d;
				end
				ST_PULSE_DIV: begin
					gate_open_q <= 1'b1;
					if (mul_pend_q && !div_wait) begin
						mul_pend_q <= 1'b0;
						php_q <= php_q + PB'(div_q);
					end
					st_q <= st_d;
				end
				ST_PULSE_LOOK: begin
					// pulse sine not above threshold closes the gate
					if (!(sinp > $signed({pulse_thr_q[14], pulse_thr_q}))) begin
						gate_open_q <= 1'b0;
						gate_q      <= pulse_floor_q;
					end
					st_q <= st_d;
				end
				ST_VOICE: begin
					if (mul_pend_q && !mul_wait) begin
						mul_pend_q <= 1'b0;
						sub_q <= (sub_q == 3'd2) ? 3'd0 : sub_q + 1'b1;
						case (sub_q)
							3'd0: ph1_q <= ph1_q + PB'(mul_p >> VSH);
							3'd1: ph2_q <= ph2_q + PB'(mul_p >> VSH);
							default: ph3_q <= ph3_q + PB'(mul_p >> VSH);
						endcase
					end
					st_q <= st_d;
				end
				ST_LOOK: begin
					mix_q <= 18'(sin1) + 18'(sin2) + 18'(sin3);
					neg_q <= (18'(sin1) + 18'(sin2) + 18'(sin3)) < 0 ? 1'b1 : 1'b0;
					st_q  <= st_d;
				end
				ST_MIX_GAIN: begin
					if (mul_pend_q && !mul_wait) begin
						mul_pend_q <= 1'b0;
						mag_q <= mul_p;
					end
					st_q <= st_d;
				end
				ST_MIX_GATE: begin
					if (gate_open_q) begin
						// open gate: times 65536
						mag_q <= mag_q << 16;
						sub_q <= '0;
					end else if (mul_pend_q && !mul_wait) begin
						mul_pend_q <= 1'b0;
						mag_q <= mul_p;
						sub_q <= '0;
					end
					st_q <= st_d;
				end
				ST_ROUND: begin
					sub_q <= 3'd1;
					if (sub_q != 3'd0 && !rdiv_ctl.busy) begin
						out_v_q <= 1'b1;
						out_l_q <= last_q;
						if (neg_q)
							out_d_q <= (rdiv_q > 80'd32768) ? 16'h8000 : 16'(-rdiv_q[16:0]);
						else
							out_d_q <= (rdiv_q > 80'd32767) ? 16'h7fff : rdiv_q[15:0];
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			st1_q  <= s_tdata[27:0];
			st2_q  <= s_tdata[55:28];
			st3_q  <= s_tdata[83:56];
			tp_q   <= s_tdata[98:84];
			tg_q   <= s_tdata[114:99];
			tr_q   <= s_tdata[130:115];
			last_q <= s_tlast;
		end
	end
endmodule

// File: sv/tvss_mul.sv
// tvss_mul: bit-serial shift-and-add multiplier, one multiplier bit per cycle
// depends on tvss_pkg
module tvss_mul import tvss_pkg::*; #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output mul_ctl_t             ctl,
	output logic [A_W+B_W-1:0]   prod
);
	localparam int CW = $clog2(B_W + 1);
	logic [CW-1:0]      cnt_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// msb first: acc = acc*2 + a*bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[A_W+B_W-2:0], 1'b0} +
				(b_q[B_W-1] ? (A_W+B_W)'(a_q) : '0);
			b_q <= {b_q[B_W-2:0], 1'b0};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign prod      = acc_q;
endmodule

// File: sv/tvss_div.sv
// tvss_div: restoring divider by a constant, one quotient bit per cycle
// depends on tvss_pkg
module tvss_div import tvss_pkg::*; #(
	parameter int N_W = 60,
	parameter int D_W = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output mul_ctl_t       ctl,
	output logic [N_W-1:0] quo
);
	localparam int CW = $clog2(N_W + 1);
	logic [CW-1:0]  cnt_q;
	logic [N_W-1:0] n_q;
	logic [D_W:0]   rem_q;
	logic           busy_q;
	logic [D_W:0]   trial;

	assign trial = {rem_q[D_W-1:0], n_q[N_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				n_q   <= {n_q[N_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				n_q   <= {n_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign quo       = n_q;
endmodule
